/* design/wfc_pkg.sv */
`timescale 1ns / 1ps

package wfc_pkg;

    // input action codes
    typedef enum logic [1:0] {
        ACT_TEXT  = 2'd0,
        ACT_FLUSH = 2'd1,
        ACT_READ  = 2'd2,
        ACT_CLEAR = 2'd3
    } wfc_action_t;

    // classified commands passed from front to back
    typedef enum logic [1:0] {
        CMD_APPEND,
        CMD_FINISH,
        CMD_READ,
        CMD_CLEAR
    } wfc_op_t;

    typedef struct packed {
        wfc_op_t     op;
        logic [7:0]  ch;
        logic [9:0]  sel;
    } wfc_cmd_t;

    typedef struct packed {
        logic [9:0]  entry_index;
        logic [23:0] word_count;
        logic [7:0]  char_out;
        logic        last;
        logic        is_new;
        logic        table_full;
        logic        truncated;
        logic        entry_valid;
    } wfc_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE,
        ST_STREAM,
        ST_REJECT
    } wfc_state_t;

    localparam int unsigned COUNT_W   = 24;
    localparam logic [23:0] COUNT_MAX = 24'hFF_FFFF;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_HYPHEN  = 8'h2D;
    localparam logic [7:0] CASE_OFFSET  = CHAR_LOWER_A - CHAR_UPPER_A;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;
    localparam int unsigned QUEUE_CW    = 3;

endpackage

/* design/wfc_front.sv */
`timescale 1ns / 1ps

module wfc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        action,
    input  logic [7:0]        text_byte,
    input  logic [9:0]        entry_select,
    output logic              cmd_valid,
    output wfc_pkg::wfc_cmd_t cmd,
    input  logic              cmd_pop
);
    import wfc_pkg::*;

    wfc_cmd_t                cls_cmd;
    wfc_cmd_t                q_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]     cnt_reg, cnt_next;
    logic                    push;
    logic                    pop;

    // classify the incoming item
    always_comb
    begin
        cls_cmd     = '0;
        cls_cmd.sel = entry_select;
        cls_cmd.op  = CMD_FINISH;
        case (wfc_action_t'(action))
            ACT_TEXT:
            begin
                if (text_byte inside {[CHAR_UPPER_A:CHAR_UPPER_Z]})
                begin
                    cls_cmd.op = CMD_APPEND;
                    cls_cmd.ch = text_byte + CASE_OFFSET;
                end
                else if (text_byte inside {[CHAR_LOWER_A:CHAR_LOWER_Z], CHAR_HYPHEN})
                begin
                    cls_cmd.op = CMD_APPEND;
                    cls_cmd.ch = text_byte;
                end
                else
                begin
                    cls_cmd.op = CMD_FINISH;
                end
            end
            ACT_FLUSH: cls_cmd.op = CMD_FINISH;
            ACT_READ:  cls_cmd.op = CMD_READ;
            ACT_CLEAR: cls_cmd.op = CMD_CLEAR;
            default:   cls_cmd.op = CMD_FINISH;
        endcase
    end

    assign in_ready  = (cnt_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QUEUE_CW'(push) - QUEUE_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls_cmd;
        end
    end

endmodule

/* design/wfc_back.sv */
`timescale 1ns / 1ps

module wfc_back #(
    parameter int unsigned MAX_WORD_CHARS = 31,
    parameter int unsigned TABLE_ENTRIES  = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  wfc_pkg::wfc_cmd_t    cmd,
    output logic                 cmd_pop,
    output logic                 res_valid,
    output wfc_pkg::wfc_result_t res,
    input  logic                 res_ready
);
    import wfc_pkg::*;

    localparam int unsigned LW  = $clog2(MAX_WORD_CHARS + 1);
    localparam int unsigned CW  = (MAX_WORD_CHARS > 1) ? $clog2(MAX_WORD_CHARS) : 1;
    localparam int unsigned IW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned TW  = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned SW  = (TW > 10) ? TW : 10;
    localparam int unsigned CHW = MAX_WORD_CHARS * 8;
    localparam int unsigned RW  = COUNT_W + LW + CHW;

    wfc_state_t        state_reg, state_next;
    logic [LW-1:0]     plen_reg, plen_next;
    logic              ptrunc_reg, ptrunc_next;
    logic [7:0]        pchars_reg [MAX_WORD_CHARS];
    logic [7:0]        pchars_next [MAX_WORD_CHARS];
    logic [TW-1:0]     tally_reg, tally_next;
    logic [TW-1:0]     scan_reg, scan_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [IW-1:0]     chk_idx_reg, chk_idx_next;
    logic              hit_reg, hit_next;
    logic [IW-1:0]     hit_idx_reg, hit_idx_next;
    logic [COUNT_W-1:0] hit_cnt_reg, hit_cnt_next;
    logic [IW-1:0]     sel_reg, sel_next;
    logic [LW-1:0]     ci_reg, ci_next;
    logic              out_valid_reg, out_valid_next;
    wfc_result_t       out_reg, out_next;

    // table row: count, length, characters
    logic [RW-1:0]     mem [TABLE_ENTRIES];
    logic [RW-1:0]     rd_data_reg;
    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [RW-1:0]     wr_data;

    logic [CHW-1:0]    pflat;
    logic [CHW-1:0]    row_chars;
    logic [LW-1:0]     row_len;
    logic [COUNT_W-1:0] row_count;
    logic [COUNT_W-1:0] count_inc;
    logic              row_match;
    logic              have_scan;
    logic              table_is_full;
    logic              sel_bad;
    logic              slot_free;
    logic              last_char;
    logic              emit;

    always_comb
    begin
        for (int i = 0; i < MAX_WORD_CHARS; i++)
        begin
            pflat[i*8 +: 8] = pchars_reg[i];
        end
    end

    assign row_chars     = rd_data_reg[CHW-1:0];
    assign row_len       = rd_data_reg[CHW+LW-1:CHW];
    assign row_count     = rd_data_reg[RW-1:CHW+LW];
    assign count_inc     = (row_count == COUNT_MAX) ? row_count : row_count + 1'b1;
    assign row_match     = chk_valid_reg && (row_len == plen_reg) && (row_chars == pflat);
    assign have_scan     = (scan_reg < tally_reg);
    assign table_is_full = (tally_reg == TW'(TABLE_ENTRIES));
    assign sel_bad       = (SW'(cmd.sel) >= SW'(tally_reg));
    assign slot_free     = !out_valid_reg || res_ready;
    assign last_char     = ((ci_reg + LW'(1)) == row_len);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        CMD_FINISH: if (plen_reg != '0) state_next = ST_SEARCH;
                        CMD_READ:   state_next = sel_bad ? ST_REJECT : ST_STREAM;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (row_match || (!have_scan && !chk_valid_reg))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:   if (slot_free) state_next = ST_IDLE;
            ST_STREAM: if (slot_free && last_char) state_next = ST_IDLE;
            ST_REJECT: if (slot_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        plen_next      = plen_reg;
        ptrunc_next    = ptrunc_reg;
        pchars_next    = pchars_reg;
        tally_next     = tally_reg;
        scan_next      = scan_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_cnt_next   = hit_cnt_reg;
        sel_next       = sel_reg;
        ci_next        = ci_reg;
        cmd_pop        = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = scan_reg[IW-1:0];
        wr_en          = 1'b0;
        wr_addr        = tally_reg[IW-1:0];
        wr_data        = {COUNT_W'(1), plen_reg, pflat};
        emit           = 1'b0;
        out_next       = out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        CMD_APPEND:
                        begin
                            if (plen_reg < LW'(MAX_WORD_CHARS))
                            begin
                                pchars_next[plen_reg[CW-1:0]] = cmd.ch;
                                plen_next = plen_reg + 1'b1;
                            end
                            else
                            begin
                                ptrunc_next = 1'b1;
                            end
                        end
                        CMD_FINISH:
                        begin
                            scan_next = '0;
                            hit_next  = 1'b0;
                        end
                        CMD_READ:
                        begin
                            sel_next = IW'(cmd.sel);
                            ci_next  = '0;
                            if (!sel_bad)
                            begin
                                rd_en   = 1'b1;
                                rd_addr = IW'(cmd.sel);
                            end
                        end
                        CMD_CLEAR: tally_next = '0;
                        default:   tally_next = tally_reg;
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (have_scan)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = scan_reg[IW-1:0];
                    scan_next = scan_reg + 1'b1;
                end
                chk_valid_next = have_scan;
                chk_idx_next   = scan_reg[IW-1:0];
                if (row_match)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = chk_idx_reg;
                    hit_cnt_next = count_inc;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    emit                 = 1'b1;
                    out_next             = '0;
                    out_next.last        = 1'b1;
                    out_next.entry_valid = 1'b1;
                    out_next.truncated   = ptrunc_reg;
                    if (hit_reg)
                    begin
                        out_next.entry_index = 10'(hit_idx_reg);
                        out_next.word_count  = hit_cnt_reg;
                        wr_en   = 1'b1;
                        wr_addr = hit_idx_reg;
                        wr_data = {hit_cnt_reg, plen_reg, pflat};
                    end
                    else if (table_is_full)
                    begin
                        out_next.table_full = 1'b1;
                    end
                    else
                    begin
                        out_next.entry_index = 10'(tally_reg);
                        out_next.word_count  = COUNT_W'(1);
                        out_next.is_new      = 1'b1;
                        wr_en      = 1'b1;
                        wr_addr    = tally_reg[IW-1:0];
                        wr_data    = {COUNT_W'(1), plen_reg, pflat};
                        tally_next = tally_reg + 1'b1;
                    end
                    plen_next   = '0;
                    ptrunc_next = 1'b0;
                    for (int i = 0; i < MAX_WORD_CHARS; i++)
                    begin
                        pchars_next[i] = '0;
                    end
                end
            end
            ST_STREAM:
            begin
                if (slot_free)
                begin
                    emit                 = 1'b1;
                    out_next             = '0;
                    out_next.entry_index = 10'(sel_reg);
                    out_next.word_count  = row_count;
                    out_next.char_out    = row_chars[int'(ci_reg)*8 +: 8];
                    out_next.last        = last_char;
                    out_next.entry_valid = 1'b1;
                    ci_next              = ci_reg + 1'b1;
                end
            end
            ST_REJECT:
            begin
                if (slot_free)
                begin
                    emit          = 1'b1;
                    out_next      = '0;
                    out_next.last = 1'b1;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            plen_reg      <= '0;
            ptrunc_reg    <= 1'b0;
            tally_reg     <= '0;
            scan_reg      <= '0;
            chk_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_WORD_CHARS; i++)
            begin
                pchars_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            plen_reg      <= plen_next;
            ptrunc_reg    <= ptrunc_next;
            tally_reg     <= tally_next;
            scan_reg      <= scan_next;
            chk_valid_reg <= chk_valid_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            pchars_reg    <= pchars_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= chk_idx_next;
        hit_idx_reg <= hit_idx_next;
        hit_cnt_reg <= hit_cnt_next;
        sel_reg     <= sel_next;
        ci_reg      <= ci_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    a_tally_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tally_reg <= TW'(TABLE_ENTRIES))
        else $error("entry tally beyond table size");

    a_plen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        plen_reg <= LW'(MAX_WORD_CHARS))
        else $error("pending word longer than maximum");

    a_write_in_done: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_DONE) && slot_free)
        else $error("table written outside word completion");

    a_chk_from_search: assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> $past(state_reg == ST_SEARCH))
        else $error("compare stage live without a search read");

endmodule

/* design/word_frequency_counter.sv */
`timescale 1ns / 1ps

// Word frequency counter. Text bytes enter one item at a time; letters (folded to lower
// case) and hyphens build a pending word, any other byte or a flush action finishes it.
// A finished word is compared against the stored table one entry per clock, stopping at
// the first match, through the single read port of the table memory; a readout returns
// one result per character. Items are classified on entry and wait in a four-deep queue,
// so up to four items are still taken while the back end walks the table, and results
// leave through an output register. No clearing pass is needed after reset: the tally
// alone says which entries hold words.
module word_frequency_counter #(
    parameter int unsigned MAX_WORD_CHARS = 31,
    parameter int unsigned TABLE_ENTRIES  = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  text_byte,
    input  logic [9:0]  entry_select,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [9:0]  entry_index,
    output logic [23:0] word_count,
    output logic [7:0]  char_out,
    output logic        last,
    output logic        is_new,
    output logic        table_full,
    output logic        truncated,
    output logic        entry_valid
);
    import wfc_pkg::*;

    wfc_cmd_t    cmd;
    logic        cmd_valid;
    logic        cmd_pop;
    wfc_result_t res;

    // front end: classify each item and queue it
    wfc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .text_byte    (text_byte),
        .entry_select (entry_select),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop)
    );

    // back end: pending word, table walk, readout and result register
    wfc_back #(
        .MAX_WORD_CHARS (MAX_WORD_CHARS),
        .TABLE_ENTRIES  (TABLE_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_valid (out_valid),
        .res       (res),
        .res_ready (out_ready)
    );

    // unpack the result item onto its ports
    assign entry_index = res.entry_index;
    assign word_count  = res.word_count;
    assign char_out    = res.char_out;
    assign last        = res.last;
    assign is_new      = res.is_new;
    assign table_full  = res.table_full;
    assign truncated   = res.truncated;
    assign entry_valid = res.entry_valid;

endmodule

/* bench/word_frequency_counter_tb.sv */
`timescale 1ns / 1ps

module word_frequency_counter_tb;
    import wfc_pkg::*;

    localparam int WORD_MAX  = 31;
    localparam int ENTRIES   = 1024;
    localparam int TAIL_WAIT = 1100;

    typedef struct {
        wfc_action_t act;
        logic [7:0]  ch;
        logic [9:0]  sel;
    } text_item_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [7:0]  text_byte;
    logic [9:0]  entry_select;
    logic        out_valid;
    logic        out_ready;
    logic [9:0]  entry_index;
    logic [23:0] word_count;
    logic [7:0]  char_out;
    logic        last;
    logic        is_new;
    logic        table_full;
    logic        truncated;
    logic        entry_valid;

    word_frequency_counter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .text_byte   (text_byte),
        .entry_select(entry_select),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .entry_index (entry_index),
        .word_count  (word_count),
        .char_out    (char_out),
        .last        (last),
        .is_new      (is_new),
        .table_full  (table_full),
        .truncated   (truncated),
        .entry_valid (entry_valid)
    );

    // predicted copy of the word store
    logic [7:0]  word_chars [ENTRIES][WORD_MAX];
    int          word_len   [ENTRIES];
    logic [23:0] word_cnt   [ENTRIES];
    int          tally;
    logic [7:0]  partial_chars [WORD_MAX];
    int          partial_len;
    bit          partial_trunc;

    text_item_t  item_q[$];
    wfc_result_t tally_results_q[$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;

    always #5 clk = ~clk;

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // finishes the pending word against the predicted store
    task automatic close_word();
        wfc_result_t r;
        bit          hit;
        int          e;
        hit = 0;
        r = '0;
        if (partial_len == 0)
            return;
        r.last = 1'b1;
        r.entry_valid = 1'b1;
        r.truncated = partial_trunc;
        partial_trunc = 0;
        for (e = 0; e < tally && !hit; e++)
        begin
            if (word_len[e] == partial_len)
            begin
                hit = 1;
                for (int i = 0; i < partial_len; i++)
                    if (word_chars[e][i] != partial_chars[i])
                        hit = 0;
                if (hit)
                begin
                    if (word_cnt[e] != COUNT_MAX)
                        word_cnt[e]++;
                    r.entry_index = 10'(e);
                    r.word_count = word_cnt[e];
                end
            end
        end
        if (!hit && tally >= ENTRIES)
            r.table_full = 1'b1;
        else if (!hit)
        begin
            for (int i = 0; i < partial_len; i++)
                word_chars[tally][i] = partial_chars[i];
            word_len[tally] = partial_len;
            word_cnt[tally] = 24'd1;
            r.entry_index = 10'(tally);
            r.word_count = 24'd1;
            r.is_new = 1'b1;
            tally++;
        end
        partial_len = 0;
        tally_results_q.push_back(r);
    endtask

    task automatic predict_item(text_item_t it);
        wfc_result_t r;
        logic [7:0]  c;
        r = '0;
        case (it.act)
            ACT_TEXT:
            begin
                c = it.ch;
                if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
                    c = c + CASE_OFFSET;
                if ((c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) || c == CHAR_HYPHEN)
                begin
                    if (partial_len < WORD_MAX)
                        partial_chars[partial_len++] = c;
                    else
                        partial_trunc = 1;
                end
                else
                    close_word();
            end
            ACT_FLUSH:
                close_word();
            ACT_READ:
            begin
                if (it.sel >= tally)
                begin
                    r.last = 1'b1;
                    tally_results_q.push_back(r);
                end
                else
                    for (int i = 0; i < word_len[it.sel]; i++)
                    begin
                        r.entry_index = it.sel;
                        r.word_count = word_cnt[it.sel];
                        r.char_out = word_chars[it.sel][i];
                        r.last = (i + 1 == word_len[it.sel]);
                        r.entry_valid = 1'b1;
                        tally_results_q.push_back(r);
                    end
            end
            default:
                tally = 0;
        endcase
    endtask

    // driver: valid stays up with a steady payload until taken
    always @(posedge clk or negedge rst_n)
    begin : driver
        text_item_t cur;
        bit         held;
        if (!rst_n)
        begin
            in_valid <= 0;
            action <= ACT_TEXT;
            text_byte <= 8'd0;
            entry_select <= 10'd0;
        end
        else
        begin
            held = in_valid;
            if (in_valid && in_ready)
            begin
                cur.act = wfc_action_t'(action);
                cur.ch = text_byte;
                cur.sel = entry_select;
                predict_item(cur);
                held = 0;
            end
            if (!held)
            begin
                if (item_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur = item_q.pop_front();
                    in_valid <= 1;
                    action <= cur.act;
                    text_byte <= cur.ch;
                    entry_select <= cur.sel;
                end
                else
                    in_valid <= 0;
            end
        end
    end

    // monitor: each result against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : monitor
        wfc_result_t w;
        if (!rst_n)
            out_ready <= 0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (tally_results_q.size() == 0)
                    report("unexpected result", entry_index, -1);
                else
                begin
                    w = tally_results_q.pop_front();
                    if (entry_index !== w.entry_index) report("entry_index", entry_index, w.entry_index);
                    if (word_count !== w.word_count)   report("word_count", word_count, w.word_count);
                    if (char_out !== w.char_out)       report("char_out", char_out, w.char_out);
                    if (last !== w.last)               report("last", last, w.last);
                    if (is_new !== w.is_new)           report("is_new", is_new, w.is_new);
                    if (table_full !== w.table_full)   report("table_full", table_full, w.table_full);
                    if (truncated !== w.truncated)     report("truncated", truncated, w.truncated);
                    if (entry_valid !== w.entry_valid) report("entry_valid", entry_valid, w.entry_valid);
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic push_item(wfc_action_t a, logic [7:0] b, logic [9:0] s);
        text_item_t it;
        it.act = a;
        it.ch = b;
        it.sel = s;
        item_q.push_back(it);
    endtask

    task automatic push_word(string w, logic [7:0] sep);
        for (int i = 0; i < w.len(); i++)
            push_item(ACT_TEXT, w[i], 10'($urandom));
        push_item(ACT_TEXT, sep, 10'($urandom));
    endtask

    // any byte that is neither a letter nor a hyphen
    function automatic logic [7:0] any_separator();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while ((b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ||
               (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) || b == CHAR_HYPHEN);
        return b;
    endfunction

    function automatic logic [7:0] any_letter();
        case ($urandom_range(2))
            0: return CHAR_LOWER_A + 8'($urandom_range(25));
            1: return CHAR_UPPER_A + 8'($urandom_range(25));
            default: return CHAR_HYPHEN;
        endcase
    endfunction

    // mostly words from a small vocabulary so that repeats hit the store
    task automatic push_random(int n);
        string vocab[8];
        string w;
        int    k;
        vocab = '{"a", "the", "Word", "co-op", "x-ray", "Counter", "zz",
                  "abcdefghijklmnopqrstuvwxyzabcdefghij"};
        k = 0;
        while (k < n)
        begin
            case ($urandom_range(19))
                0, 1: push_item(ACT_FLUSH, 8'($urandom), 10'($urandom));
                2, 3: push_item(ACT_READ, 8'($urandom),
                                10'(($urandom_range(3) == 0) ? $urandom
                                                             : $urandom_range(tally + 8)));
                4:    push_item(ACT_CLEAR, 8'($urandom), 10'($urandom));
                5:    push_item(ACT_TEXT, 8'($urandom), 10'($urandom));
                6, 7, 8:
                begin
                    w = "";
                    repeat ($urandom_range(1, 34))
                        w = {w, string'(any_letter())};
                    push_word(w, any_separator());
                    k += w.len();
                end
                default:
                begin
                    w = vocab[$urandom_range(7)];
                    for (int i = 0; i < w.len(); i++)
                        if ($urandom_range(1) && w[i] >= "a" && w[i] <= "z")
                            w[i] = w[i] - CASE_OFFSET;
                    push_word(w, any_separator());
                    k += w.len();
                end
            endcase
            k++;
        end
    endtask

    task automatic drain();
        while (item_q.size() > 0 || in_valid || tally_results_q.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        tally = 0;
        partial_len = 0;
        partial_trunc = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;

        // directed: empty separators, case folding, hyphen, truncation, readouts, clear
        push_item(ACT_TEXT, 8'h00, 10'h3FF);
        push_item(ACT_FLUSH, 8'hFF, 10'd0);
        push_word("Hello", 8'hFF);
        push_word("hELLO", 8'h20);
        push_word("-", 8'h00);
        push_word("abcdefghijklmnopqrstuvwxyzABCDEFGH", 8'h80);
        push_item(ACT_TEXT, "z", 10'd0);
        push_item(ACT_FLUSH, 8'd0, 10'd0);
        push_item(ACT_READ, 8'd0, 10'd0);
        push_item(ACT_READ, 8'd0, 10'd2);
        push_item(ACT_READ, 8'd0, 10'h3FF);
        push_item(ACT_TEXT, "q", 10'd0);
        push_item(ACT_CLEAR, 8'd0, 10'd0);
        push_item(ACT_READ, 8'd0, 10'd0);
        push_item(ACT_FLUSH, 8'd0, 10'd0);
        drain();

        // random phases with varying back-pressure, pausing for the results each time
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            push_random(100);
            drain();
        end

        repeat (TAIL_WAIT) @(posedge clk);
        if (mismatches == 0 && tally_results_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
design/wfc_pkg.sv
design/wfc_front.sv
design/wfc_back.sv
design/word_frequency_counter.sv
bench/word_frequency_counter_tb.sv
